// ===== rtl/icmp_echo_request_builder_defines.svh =====
// Assertion macros shared by the checker of the ICMP echo request builder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ICMP_ECHO_REQUEST_BUILDER_DEFINES_SVH
`define ICMP_ECHO_REQUEST_BUILDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ERB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icmp echo builder assertion failed");

// Next-cycle implication, checked out of reset.
`define ERB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icmp echo builder assertion failed");

`endif

// ===== rtl/icmp_erb_pkg.sv =====
// Package of the ICMP echo request builder: field widths, protocol constants,
// register indexes, controller states and the controller/datapath structs.
// No dependencies.
package icmp_erb_pkg;

    localparam int SEQ_W      = 16;
    localparam int ID_W       = 16;
    localparam int SIZE_W     = 10;
    localparam int DATA_W     = 64;
    localparam int BYTES_W    = 4;
    localparam int SUM_W      = 24;
    localparam int BEAT_BYTES = 8;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [7:0]         ECHO_TYPE       = 8'h08;
    localparam logic [7:0]         ECHO_CODE       = 8'h00;
    localparam logic [7:0]         FILL_BYTE       = 8'h78;
    localparam logic [15:0]        FILL_WORD       = 16'h7878;
    localparam logic [15:0]        FILL_ODD        = 16'h7800;
    localparam logic [SIZE_W-1:0]  HDR_BYTES       = 10'd8;
    localparam logic [BYTES_W-1:0] BEAT_FULL       = 4'd8;
    localparam logic [ID_W-1:0]    ECHO_ID_RST     = 16'd0;
    localparam logic [SIZE_W-1:0]  PACKET_SIZE_RST = 10'd64;

    localparam logic [REG_IDX_W-1:0] REG_ECHO_ID     = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PACKET_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_FOLD,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic sum;
        logic fold;
        logic next_beat;
    } dp_cmd_t;

    typedef struct packed {
        logic last_beat;
    } dp_sts_t;

endpackage

// ===== rtl/icmp_erb_ifs.sv =====
// Valid/ready channel interfaces of the ICMP echo request builder:
// the sequence number request channel and the output beat channel.
// Depends on icmp_erb_pkg.
interface icmp_erb_seq_if;
    logic                          valid;
    logic                          ready;
    logic [icmp_erb_pkg::SEQ_W-1:0] seq;

    modport source (output valid, output seq, input ready);
    modport sink (input valid, input seq, output ready);
endinterface

interface icmp_erb_beat_if;
    logic                            valid;
    logic                            ready;
    logic [icmp_erb_pkg::DATA_W-1:0]  beat_data;
    logic [icmp_erb_pkg::BYTES_W-1:0] beat_bytes;
    logic                            beat_last;

    modport source (output valid, output beat_data, output beat_bytes, output beat_last,
                    input ready);
    modport sink (input valid, input beat_data, input beat_bytes, input beat_last,
                  output ready);
endinterface

// ===== rtl/icmp_erb_regs.sv =====
// APB-style configuration registers: echo identifier and packet size.
// Depends on icmp_erb_pkg.
module icmp_erb_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [icmp_erb_pkg::PADDR_W-1:0]   paddr,
    input  logic [icmp_erb_pkg::PDATA_W-1:0]   pwdata,
    output logic [icmp_erb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [icmp_erb_pkg::ID_W-1:0]      echo_id,
    output logic [icmp_erb_pkg::SIZE_W-1:0]    packet_size
);

    logic [icmp_erb_pkg::ID_W-1:0]      echo_id_reg;
    logic [icmp_erb_pkg::ID_W-1:0]      echo_id_next;
    logic [icmp_erb_pkg::SIZE_W-1:0]    packet_size_reg;
    logic [icmp_erb_pkg::SIZE_W-1:0]    packet_size_next;
    logic [icmp_erb_pkg::REG_IDX_W-1:0] reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[icmp_erb_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        echo_id_next     = echo_id_reg;
        packet_size_next = packet_size_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                icmp_erb_pkg::REG_ECHO_ID:
                    echo_id_next = pwdata[icmp_erb_pkg::ID_W-1:0];
                icmp_erb_pkg::REG_PACKET_SIZE:
                    packet_size_next = pwdata[icmp_erb_pkg::SIZE_W-1:0];
                default:
                    echo_id_next = echo_id_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            icmp_erb_pkg::REG_ECHO_ID:
                prdata = icmp_erb_pkg::PDATA_W'(echo_id_reg);
            icmp_erb_pkg::REG_PACKET_SIZE:
                prdata = icmp_erb_pkg::PDATA_W'(packet_size_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_id_reg     <= icmp_erb_pkg::ECHO_ID_RST;
            packet_size_reg <= icmp_erb_pkg::PACKET_SIZE_RST;
        end
        else
        begin
            echo_id_reg     <= echo_id_next;
            packet_size_reg <= packet_size_next;
        end
    end

    assign echo_id     = echo_id_reg;
    assign packet_size = packet_size_reg;

endmodule

// ===== rtl/icmp_erb_ctrl.sv =====
// Controller of the ICMP echo request builder: sequences capture, checksum
// sum, checksum fold and beat transmission. Depends on icmp_erb_pkg.
module icmp_erb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  beat_valid,
    input  logic                  beat_ready,
    output icmp_erb_pkg::dp_cmd_t cmd,
    input  icmp_erb_pkg::dp_sts_t sts
);

    icmp_erb_pkg::ctrl_state_t state_reg;
    icmp_erb_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icmp_erb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        beat_valid = 1'b0;
        unique case (state_reg)
            icmp_erb_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = icmp_erb_pkg::ST_SUM;
                end
            end
            icmp_erb_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = icmp_erb_pkg::ST_FOLD;
            end
            icmp_erb_pkg::ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = icmp_erb_pkg::ST_SEND;
            end
            icmp_erb_pkg::ST_SEND:
            begin
                beat_valid = 1'b1;
                if (beat_ready)
                begin
                    cmd.next_beat = 1'b1;
                    if (sts.last_beat)
                    begin
                        state_next = icmp_erb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = icmp_erb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/icmp_erb_dp.sv =====
// Datapath of the ICMP echo request builder: size clamp, closed-form
// Internet checksum, beat counter and beat formatting. Depends on icmp_erb_pkg.
module icmp_erb_dp
#(
    parameter int MAX_BYTES = 512
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  icmp_erb_pkg::dp_cmd_t                cmd,
    output icmp_erb_pkg::dp_sts_t                sts,
    input  logic [icmp_erb_pkg::SEQ_W-1:0]       seq,
    input  logic [icmp_erb_pkg::ID_W-1:0]        echo_id,
    input  logic [icmp_erb_pkg::SIZE_W-1:0]      packet_size,
    output logic [icmp_erb_pkg::DATA_W-1:0]      beat_data,
    output logic [icmp_erb_pkg::BYTES_W-1:0]     beat_bytes,
    output logic                                 beat_last
);

    localparam int BEATS_MAX =
        (MAX_BYTES + icmp_erb_pkg::BEAT_BYTES - 1) / icmp_erb_pkg::BEAT_BYTES;
    localparam int BIDX_W = (BEATS_MAX > 1) ? $clog2(BEATS_MAX) : 1;
    localparam logic [icmp_erb_pkg::SIZE_W-1:0] MAX_SIZE = icmp_erb_pkg::SIZE_W'(MAX_BYTES);

    logic [icmp_erb_pkg::SEQ_W-1:0]  seq_reg;
    logic [icmp_erb_pkg::SEQ_W-1:0]  seq_next;
    logic [icmp_erb_pkg::SIZE_W-1:0] size_reg;
    logic [icmp_erb_pkg::SIZE_W-1:0] size_next;
    logic [icmp_erb_pkg::SUM_W-1:0]  sum_reg;
    logic [icmp_erb_pkg::SUM_W-1:0]  sum_next;
    logic [15:0]                     cks_reg;
    logic [15:0]                     cks_next;
    logic [BIDX_W-1:0]               beat_idx_reg;
    logic [BIDX_W-1:0]               beat_idx_next;

    logic [icmp_erb_pkg::SIZE_W-1:0] eff_size;
    logic [icmp_erb_pkg::SIZE_W-1:0] pay;
    logic [icmp_erb_pkg::SUM_W-1:0]  pay_sum;
    logic [16:0]                     fold1;
    logic [16:0]                     fold2;
    logic [icmp_erb_pkg::SIZE_W-1:0] start;
    logic [icmp_erb_pkg::SIZE_W-1:0] left;
    logic                            is_last;
    logic [icmp_erb_pkg::BYTES_W-1:0] cnt;

    always_comb
    begin
        if (packet_size < icmp_erb_pkg::HDR_BYTES)
        begin
            eff_size = icmp_erb_pkg::HDR_BYTES;
        end
        else if (packet_size > MAX_SIZE)
        begin
            eff_size = MAX_SIZE;
        end
        else
        begin
            eff_size = packet_size;
        end
    end

    // The payload is constant, so its contribution to the sum is a product.
    assign pay     = size_reg - icmp_erb_pkg::HDR_BYTES;
    assign pay_sum = icmp_erb_pkg::SUM_W'(pay[icmp_erb_pkg::SIZE_W-1:1])
                     * icmp_erb_pkg::SUM_W'(icmp_erb_pkg::FILL_WORD)
                     + (pay[0] ? icmp_erb_pkg::SUM_W'(icmp_erb_pkg::FILL_ODD) : '0);

    assign fold1 = 17'(sum_reg[icmp_erb_pkg::SUM_W-1:16]) + 17'(sum_reg[15:0]);
    assign fold2 = 17'(fold1[16]) + 17'(fold1[15:0]);

    always_comb
    begin
        seq_next      = seq_reg;
        size_next     = size_reg;
        sum_next      = sum_reg;
        cks_next      = cks_reg;
        beat_idx_next = beat_idx_reg;
        if (cmd.load)
        begin
            seq_next      = seq;
            size_next     = eff_size;
            beat_idx_next = '0;
        end
        if (cmd.sum)
        begin
            sum_next = icmp_erb_pkg::SUM_W'({icmp_erb_pkg::ECHO_TYPE, 8'h00})
                       + icmp_erb_pkg::SUM_W'(echo_id)
                       + icmp_erb_pkg::SUM_W'(seq_reg)
                       + pay_sum;
        end
        if (cmd.fold)
        begin
            cks_next = ~fold2[15:0];
        end
        if (cmd.next_beat)
        begin
            beat_idx_next = beat_idx_reg + BIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_idx_reg <= '0;
        end
        else
        begin
            beat_idx_reg <= beat_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg  <= seq_next;
        size_reg <= size_next;
        sum_reg  <= sum_next;
        cks_reg  <= cks_next;
    end

    assign start   = icmp_erb_pkg::SIZE_W'(beat_idx_reg) << 3;
    assign left    = size_reg - start;
    assign is_last = (left <= icmp_erb_pkg::SIZE_W'(icmp_erb_pkg::BEAT_BYTES));
    assign cnt     = is_last ? left[icmp_erb_pkg::BYTES_W-1:0] : icmp_erb_pkg::BEAT_FULL;

    always_comb
    begin
        if (beat_idx_reg == '0)
        begin
            beat_data = {icmp_erb_pkg::ECHO_TYPE, icmp_erb_pkg::ECHO_CODE,
                         cks_reg, echo_id, seq_reg};
        end
        else
        begin
            for (int k = 0; k < icmp_erb_pkg::BEAT_BYTES; k++)
            begin
                beat_data[icmp_erb_pkg::DATA_W-1-8*k -: 8] =
                    (icmp_erb_pkg::BYTES_W'(k) < cnt) ? icmp_erb_pkg::FILL_BYTE : 8'h00;
            end
        end
    end

    assign beat_bytes    = cnt;
    assign beat_last     = is_last;
    assign sts.last_beat = is_last;

endmodule

// ===== rtl/icmp_echo_request_builder.sv =====
// ICMP echo request builder: one sequence number in, one echo request out as 8-byte beats.
// The first beat is valid after the sum and fold states that follow the request transaction.
// One request per packet of nbeats = ceil(size / 8) beats, up to 64, taken only in idle;
// the beat counter in the datapath sets the pace at one beat per cycle without back-pressure.
// Reset (rst_n, asynchronous, active low) returns the controller to idle, echo_id to 0
// and packet_size to 64.
module icmp_echo_request_builder
#(
    parameter int MAX_BYTES = 512
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    icmp_erb_seq_if.sink                       req,
    icmp_erb_beat_if.source                    beat,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [icmp_erb_pkg::PADDR_W-1:0]   paddr,
    input  logic [icmp_erb_pkg::PDATA_W-1:0]   pwdata,
    output logic [icmp_erb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [icmp_erb_pkg::ID_W-1:0]   echo_id;
    logic [icmp_erb_pkg::SIZE_W-1:0] packet_size;
    icmp_erb_pkg::dp_cmd_t           cmd;
    icmp_erb_pkg::dp_sts_t           sts;

    icmp_erb_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .echo_id     (echo_id),
        .packet_size (packet_size)
    );

    icmp_erb_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .beat_valid (beat.valid),
        .beat_ready (beat.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    icmp_erb_dp
    #(
        .MAX_BYTES (MAX_BYTES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .seq         (req.seq),
        .echo_id     (echo_id),
        .packet_size (packet_size),
        .beat_data   (beat.beat_data),
        .beat_bytes  (beat.beat_bytes),
        .beat_last   (beat.beat_last)
    );

endmodule

// ===== rtl/icmp_erb_checker.sv =====
// Port-level checker for the ICMP echo request builder, bound to the top level.
// Depends on icmp_erb_pkg and icmp_echo_request_builder_defines.svh.
`include "icmp_echo_request_builder_defines.svh"

module icmp_erb_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               beat_valid,
    input logic                               beat_ready,
    input logic [icmp_erb_pkg::DATA_W-1:0]    beat_data,
    input logic [icmp_erb_pkg::BYTES_W-1:0]   beat_bytes,
    input logic                               beat_last
);

    logic short_beat;
    logic beat_stall;

    assign short_beat = beat_valid && (beat_bytes != icmp_erb_pkg::BEAT_FULL);
    assign beat_stall = beat_valid && !beat_ready;

    // A short beat can only close the packet.
    `ERB_ASSERT_IMP(a_short_beat_is_last, short_beat, beat_last)

    // No new request is taken while a packet is being sent.
    `ERB_ASSERT_IMP(a_no_req_while_sending, beat_valid, !req_ready)

    // The checksum passes through the sum and fold states, so no beat follows a request transaction at once.
    `ERB_ASSERT_NEXT(a_gap_after_req, req_valid && req_ready, !beat_valid)

    // A stalled beat holds its contents.
    `ERB_ASSERT_NEXT(a_beat_holds, beat_stall, beat_valid && $stable({beat_data, beat_last}))

endmodule

bind icmp_echo_request_builder icmp_erb_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .beat_valid (beat.valid),
    .beat_ready (beat.ready),
    .beat_data  (beat.beat_data),
    .beat_bytes (beat.beat_bytes),
    .beat_last  (beat.beat_last)
);

// ===== bench/icmp_echo_request_checker.sv =====
// Checker of the ICMP echo request builder: watches the request, beat and register channels,
// predicts every beat of each echo request and compares it with the beats the block delivers.
// Depends on icmp_erb_pkg and the channel interfaces in icmp_erb_ifs.
module icmp_echo_request_checker
    import icmp_erb_pkg::*;
#(
    parameter int MAX_BYTES = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    icmp_erb_seq_if            req,
    icmp_erb_beat_if           beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 beats_due
);

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [BYTES_W-1:0] nbytes;
        logic               last;
    } echo_beat_t;

    echo_beat_t        echo_beats[$];
    logic [ID_W-1:0]   echo_id     = ECHO_ID_RST;
    logic [SIZE_W-1:0] packet_size = PACKET_SIZE_RST;
    int                n_fail      = 0;
    int                n_due       = 0;

    assign fail_count = n_fail;
    assign beats_due  = n_due;

    function automatic logic [15:0] echo_checksum(input logic [15:0] seq_no,
                                                  input logic [31:0] size);
        logic [31:0] pay;
        logic [31:0] sum;
        pay = size - 32'(HDR_BYTES);
        sum = {16'h0, ECHO_TYPE, ECHO_CODE} + 32'(echo_id) + 32'(seq_no)
              + (pay >> 1) * 32'(FILL_WORD);
        if (pay[0])
        begin
            sum = sum + 32'(FILL_ODD);
        end
        sum = (sum >> 16) + (sum & 32'hFFFF);
        sum = sum + (sum >> 16);
        return ~sum[15:0];
    endfunction

    function automatic void queue_echo_request(input logic [15:0] seq_no);
        logic [31:0] size;
        logic [31:0] nbeats;
        logic [31:0] cnt;
        logic [15:0] cks;
        echo_beat_t  b;
        size = 32'(packet_size);
        if (size < 32'(HDR_BYTES))
        begin
            size = 32'(HDR_BYTES);
        end
        if (size > MAX_BYTES)
        begin
            size = MAX_BYTES;
        end
        cks    = echo_checksum(seq_no, size);
        nbeats = (size + BEAT_BYTES - 1) / BEAT_BYTES;
        for (int i = 0; i < nbeats; i++)
        begin
            cnt = size - i * BEAT_BYTES;
            if (cnt > BEAT_BYTES)
            begin
                cnt = BEAT_BYTES;
            end
            if (i == 0)
            begin
                b.data = {ECHO_TYPE, ECHO_CODE, cks, echo_id, seq_no};
            end
            else
            begin
                b.data = '0;
                for (int k = 0; k < cnt; k++)
                begin
                    b.data[DATA_W-1-8*k -: 8] = FILL_BYTE;
                end
            end
            b.nbytes = cnt[BYTES_W-1:0];
            b.last   = (i + 1 == nbeats);
            echo_beats.push_back(b);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        echo_beat_t want;
        if (!rst_n)
        begin
            echo_id     = ECHO_ID_RST;
            packet_size = PACKET_SIZE_RST;
            echo_beats.delete();
        end
        else
        begin
            if (beat.valid && beat.ready)
            begin
                if (echo_beats.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected beat, expected none, got %h bytes %0d last %b",
                             $time, beat.beat_data, beat.beat_bytes, beat.beat_last);
                end
                else
                begin
                    want = echo_beats.pop_front();
                    if (beat.beat_data !== want.data)
                    begin
                        n_fail++;
                        $display("%0t: beat_data expected %h, got %h",
                                 $time, want.data, beat.beat_data);
                    end
                    if (beat.beat_bytes !== want.nbytes)
                    begin
                        n_fail++;
                        $display("%0t: beat_bytes expected %0d, got %0d",
                                 $time, want.nbytes, beat.beat_bytes);
                    end
                    if (beat.beat_last !== want.last)
                    begin
                        n_fail++;
                        $display("%0t: beat_last expected %b, got %b",
                                 $time, want.last, beat.beat_last);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                queue_echo_request(req.seq);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_ECHO_ID)
                begin
                    echo_id = pwdata[ID_W-1:0];
                end
                else if (paddr[PADDR_W-1:2] == REG_PACKET_SIZE)
                begin
                    packet_size = pwdata[SIZE_W-1:0];
                end
            end
        end
        n_due = echo_beats.size();
    end

endmodule

// ===== bench/tb_icmp_echo_request_builder.sv =====
// Top of the ICMP echo request builder testbench: clock, reset, register writes,
// sequence number stimulus and beat back-pressure, with the verdict at the end.
// Depends on icmp_erb_pkg, icmp_erb_ifs, the block and icmp_echo_request_checker.
module tb_icmp_echo_request_builder;
    import icmp_erb_pkg::*;

    localparam int MAX_BYTES   = 512;
    localparam int ITEM_TARGET = 330;
    localparam int QUIET_ITEMS = 40;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 4000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    icmp_erb_seq_if  req();
    icmp_erb_beat_if beat();

    int fail_count;
    int beats_due;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit req_gaps    = 1'b0;

    icmp_echo_request_builder #(.MAX_BYTES(MAX_BYTES)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .beat    (beat),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    icmp_echo_request_checker #(.MAX_BYTES(MAX_BYTES)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .beat       (beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .beats_due  (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Unused upper data bits are randomised; the block must ignore them.
    task automatic set_config(input bit wr_id, input logic [ID_W-1:0] id,
                              input bit wr_size, input logic [SIZE_W-1:0] size);
        logic [PDATA_W-1:0] value;
        if (wr_id)
        begin
            value           = $urandom;
            value[ID_W-1:0] = id;
            write_reg(REG_ECHO_ID, value);
        end
        if (wr_size)
        begin
            value             = $urandom;
            value[SIZE_W-1:0] = size;
            write_reg(REG_PACKET_SIZE, value);
        end
    endtask

    task automatic send_seq(input logic [SEQ_W-1:0] seq_no);
        req.valid <= 1'b1;
        req.seq   <= seq_no;
        do
        begin
            @(negedge clk);
        end
        while (!req.ready);
        @(posedge clk);
        items_sent++;
        if (req_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_beats();
        req.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (beats_due != 0);
        @(posedge clk);
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req)
            begin
                beat.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                beat.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                beat.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (beat.valid && beat.ready) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int                n;
        bit                held;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req.valid  = 1'b0;
        req.seq    = '0;
        beat.ready = 1'b0;
        held       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first, then the size clamps, odd sizes and partial last beats.
        req_gaps = 1'b1;
        send_seq(16'h0000);
        send_seq(16'hFFFF);
        drain_beats();
        set_config(1'b1, 16'hFFFF, 1'b1, 10'd0);
        send_seq(16'hFFFF);
        send_seq(16'h0000);
        drain_beats();
        set_config(1'b0, 16'h0000, 1'b1, 10'd7);
        send_seq(16'h1234);
        drain_beats();
        set_config(1'b1, 16'h0000, 1'b1, 10'd8);
        send_seq(16'h0001);
        drain_beats();
        set_config(1'b1, 16'h8001, 1'b1, 10'd9);
        send_seq(16'h8001);
        drain_beats();
        set_config(1'b0, 16'h0000, 1'b1, 10'd15);
        send_seq(16'h5555);
        drain_beats();
        set_config(1'b1, 16'h7FFF, 1'b1, 10'd16);
        send_seq(16'hAAAA);
        drain_beats();
        set_config(1'b0, 16'h0000, 1'b1, 10'd17);
        send_seq(16'hFFFE);
        drain_beats();
        set_config(1'b1, 16'h8000, 1'b1, 10'd512);
        send_seq(16'hAAAA);
        drain_beats();
        set_config(1'b1, 16'hFFFF, 1'b1, 10'd513);
        send_seq(16'h5555);
        drain_beats();
        set_config(1'b0, 16'h0000, 1'b1, 10'd1023);
        send_seq(16'hFFFF);
        drain_beats();

        while (items_sent < ITEM_TARGET)
        begin
            quiet    = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
            req_gaps = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 3))
                0:       id = 16'h0000;
                1:       id = 16'hFFFF;
                default: id = ID_W'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 11))
                0:       size = SIZE_W'($urandom_range(0, 7));
                1:       size = SIZE_W'($urandom_range(500, 1023));
                default: size = SIZE_W'($urandom_range(8, 80));
            endcase
            case ($urandom_range(0, 3))
                0:       set_config(1'b1, id, 1'b0, size);
                1:       set_config(1'b0, id, 1'b1, size);
                default: set_config(1'b1, id, 1'b1, size);
            endcase
            if (!held && items_sent >= 100)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            n = $urandom_range(4, 16);
            repeat (n) send_seq(SEQ_W'($urandom_range(0, 16'hFFFF)));
            drain_beats();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/icmp_erb_pkg.sv
rtl/icmp_erb_ifs.sv
rtl/icmp_erb_regs.sv
rtl/icmp_erb_ctrl.sv
rtl/icmp_erb_dp.sv
rtl/icmp_echo_request_builder.sv
rtl/icmp_erb_checker.sv
bench/icmp_echo_request_checker.sv
bench/tb_icmp_echo_request_builder.sv
